[rtl/sha_pkg.sv]
`timescale 1ns / 1ps
package sha_pkg;

  localparam int CountBitsDefault = 61;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LengthPos = 6'd56;

  function automatic logic [31:0] init_chain(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  localparam logic [31:0] RoundConsts [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[rtl/sha256_stream_hash.sv]
`timescale 1ns / 1ps
// The word that completes a block closes input while the block streams out of the byte
// memory, the rounds run at one per cycle and the chain words are folded in.
// Final word: pad bytes go into the byte memory one per cycle up to byte 63, then one
// compression, or two when the length no longer fits; 8 digest words follow.
// Throughput: 1 byte/cycle inside a block; input stays closed while a 64-byte block is hashed.
// Sync reset restores initial chain words and clears counts; memories are not cleared.
module sha256_stream_hash #(
  parameter int COUNT_BITS = sha_pkg::CountBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // byte_valid
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_tlast    // last_word
);
  import sha_pkg::*;

  state_t state, state_next;
  logic [5:0] fill;
  logic [COUNT_BITS-1:0] total;
  logic [31:0] chain [8];
  logic [31:0] rv [8];
  logic [6:0] ld;
  logic [5:0] rnd;
  logic [2:0] oidx;
  logic fin;                          // message end seen, padding owed
  logic mark_done;                    // 0x80 already written
  logic len_blk;                      // current pad block carries the bit length

  // byte store: 64 x 8, sync read
  logic [7:0] bmem [64];
  logic [5:0] bwa, bra;
  logic [7:0] bwd, brd;
  logic bwe;
  // schedule window: 16 x 32 shift line, w[0] is the word for the current round
  logic [31:0] w [16];

  logic acc;
  logic [63:0] bitlen;
  logic [7:0] padbyte;
  logic [31:0] wt, t1, t2, s0, s1, wn;

  assign s_tready = (state == ST_COLLECT);
  assign acc = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (bwe) bmem[bwa] <= bwd;
    brd <= bmem[bra];
  end

  // pad byte for position fill
  always_comb begin
    bitlen = 64'(total) << 3;
    padbyte = 8'h00;
    if (!mark_done) padbyte = PadMark;
    else if (len_blk && fill >= LengthPos) padbyte = 8'(bitlen >> {~fill[2:0], 3'b000});
  end

  always_comb begin
    bwe = 1'b0;
    bwa = fill;
    bwd = s_tdata;
    if (acc && s_tuser) bwe = 1'b1;
    else if (state == ST_PAD) begin
      bwe = 1'b1;
      bwd = padbyte;
    end
    bra = ld[5:0];
  end

  always_comb begin
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    wn = s1 + w[9] + s0 + w[0];
    wt = w[0];
    t1 = rv[7] + (rotr(rv[4], 6) ^ rotr(rv[4], 11) ^ rotr(rv[4], 25))
       + ((rv[4] & rv[5]) ^ (~rv[4] & rv[6])) + RoundConsts[rnd] + wt;
    t2 = (rotr(rv[0], 2) ^ rotr(rv[0], 13) ^ rotr(rv[0], 22))
       + ((rv[0] & rv[1]) ^ (rv[0] & rv[2]) ^ (rv[1] & rv[2]));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (acc && s_tuser && fill == 6'd63) state_next = ST_LOAD;
        else if (acc && s_tlast) state_next = ST_PAD;
      end
      ST_PAD:   if (fill == 6'd63) state_next = ST_LOAD;
      ST_LOAD:  if (ld == 7'd64) state_next = ST_ROUND;
      ST_ROUND: if (rnd == 6'd63) state_next = ST_FINAL;
      ST_FINAL: begin
        if (!fin) state_next = ST_COLLECT;
        else if (mark_done && len_blk) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT:  if (m_tready && oidx == 3'd7) state_next = ST_COLLECT;
      default:  state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    m_tvalid = (state == ST_EMIT);
    m_tlast  = (oidx == 3'd7);
    m_tdata  = {5'd0, oidx, chain[oidx]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      fill <= '0;
      total <= '0;
      ld <= '0;
      rnd <= '0;
      oidx <= '0;
      fin <= 1'b0;
      mark_done <= 1'b0;
      len_blk <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= init_chain(3'(i));
    end else begin
      state <= state_next;
      case (state)
        ST_COLLECT: begin
          ld <= '0;
          if (acc && s_tuser) begin
            fill <= fill + 6'd1;      // wraps to 0 when the block is full
            total <= total + 1'b1;
          end
          if (acc && s_tlast) fin <= 1'b1;
        end
        ST_PAD: begin
          ld <= '0;
          fill <= fill + 6'd1;
          if (!mark_done) begin
            mark_done <= 1'b1;
            len_blk <= (fill < LengthPos);
          end
        end
        ST_LOAD: begin
          ld <= ld + 7'd1;
          // read data follows its address in the next cycle; shift bytes in big-endian
          if (ld != 7'd0) begin
            for (int i = 0; i < 15; i++) w[i] <= {w[i][23:0], w[i+1][31:24]};
            w[15] <= {w[15][23:0], brd};
          end
          for (int i = 0; i < 8; i++) rv[i] <= chain[i];
          rnd <= '0;
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wn;
          for (int i = 1; i < 8; i++) rv[i] <= rv[i-1];
          rv[4] <= rv[3] + t1;
          rv[0] <= t1 + t2;
        end
        ST_FINAL: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + rv[i];
          oidx <= '0;
          // after the overflow pad block the next one takes the length
          if (mark_done) len_blk <= 1'b1;
        end
        ST_EMIT: if (m_tready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            fill <= '0;
            total <= '0;
            fin <= 1'b0;
            mark_done <= 1'b0;
            len_blk <= 1'b0;
            for (int i = 0; i < 8; i++) chain[i] <= init_chain(3'(i));
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input open while emitting");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == 6'd63) |=> state == ST_FINAL)
    else $error("round count slip");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> state == ST_COLLECT && fill == 6'd0)
    else $error("no restart after digest");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");
endmodule

[dv/tb_sha256_stream_hash.sv]
`timescale 1ns / 1ps
module tb_sha256_stream_hash;
  import sha_pkg::*;

  localparam int CycleLimit = 2000000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // data_byte
  logic        s_tuser;   // byte_valid
  logic        s_tlast;   // end_of_message
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // digest_word[31:0], word_index[34:32], zero fill
  logic        m_tlast;   // last_word

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  sha256_stream_hash dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [60:0] msg_bytes;
  digest_word_t digest_q[$];

  int errors;
  int burst_left;
  int hold_off;
  bit sender_busy;
  longint unsigned cycles;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int k = 0; k < 16; k++)
      w[k] = {blk[4*k], blk[4*k+1], blk[4*k+2], blk[4*k+3]};
    for (int k = 16; k < 64; k++) begin
      s1 = ror(w[k-2], 17) ^ ror(w[k-2], 19) ^ (w[k-2] >> 10);
      s0 = ror(w[k-15], 7) ^ ror(w[k-15], 18) ^ (w[k-15] >> 3);
      w[k] = w[k-16] + s0 + w[k-7] + s1;
    end
    for (int k = 0; k < 8; k++) v[k] = chain[k];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConsts[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int k = 7; k > 0; k--) v[k] = v[k-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) chain[k] = chain[k] + v[k];
  endfunction

  function automatic void restart_hash();
    chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    fill = 0;
    msg_bytes = '0;
  endfunction

  function automatic void predict_hash(logic [7:0] b, logic has_byte, logic eom);
    logic [63:0] bits;
    if (has_byte) begin
      blk[fill] = b;
      fill++;
      msg_bytes = msg_bytes + 1'b1;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (!eom) return;
    blk[fill] = PadMark;
    fill++;
    if (fill > LengthPos) begin
      while (fill < 64) blk[fill++] = 8'h00;
      compress();
      fill = 0;
    end
    while (fill < LengthPos) blk[fill++] = 8'h00;
    bits = {msg_bytes, 3'b000};
    for (int k = 0; k < 8; k++) blk[LengthPos + k] = bits[63 - 8*k -: 8];
    compress();
    for (int k = 0; k < 8; k++)
      digest_q.push_back('{chain[k], 3'(k), k == 7});
    restart_hash();
  endfunction

  task automatic send_word(logic [7:0] b, logic has_byte, logic eom);
    int gap;
    // bursty sender: random gap once a burst runs out
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= has_byte;
    s_tlast  <= eom;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_hash(b, has_byte, eom);
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit empty_last, bit fixed, logic [7:0] val);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(fixed ? val : 8'($urandom), 1'b1, (i == len - 1) && !empty_last);
    end
    if (empty_last || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (digest_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_message(0, 1'b1, 1'b0, 8'h00);   // empty message
    send_message(3, 1'b0, 1'b0, 8'h00);   // byte on final word
    send_message(1, 1'b0, 1'b1, 8'hff);
    send_message(1, 1'b0, 1'b1, 8'h00);
    send_message(2, 1'b1, 1'b0, 8'h00);   // short message, empty final word
    send_word(8'h5a, 1'b0, 1'b0);         // ignored word
    send_message(0, 1'b1, 1'b0, 8'h00);
  endtask

  task automatic test_pad_boundaries();
    // 56 pushes the length into a second block; 64 ends on the word that fills a block
    send_message(56, 1'b0, 1'b0, 8'h00);
    send_message(64, 1'b0, 1'b1, 8'hff);
  endtask

  task automatic test_backpressure();
    // first digest is held while the next message keeps offering words
    hold_off = 400;
    send_message(3, 1'b0, 1'b0, 8'h00);
    send_message(20, 1'b0, 1'b0, 8'h00);
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    int len;
    sent = 0;
    while (sent < 20) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 20);
      send_message(len, $urandom_range(0, 3) == 0, 1'b0, 8'h00);
      sent += len + 1;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  // receiver stall pattern, with long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (cycles % 256 < 64) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    digest_word_t got, want;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[31:0], m_tdata[34:32], m_tlast};
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h", $time, got);
        errors++;
      end else begin
        want = digest_q.pop_front();
        if (got.digest !== want.digest)
          $display("%0t: digest exp %h got %h", $time, want.digest, got.digest);
        if (got.index !== want.index)
          $display("%0t: index exp %0d got %0d", $time, want.index, got.index);
        if (got.last !== want.last)
          $display("%0t: last exp %b got %b", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int tail;
    errors = 0;
    cycles = 0;
    burst_left = 0;
    hold_off = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    restart_hash();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_pad_boundaries();
    test_backpressure();
    test_random();
    wait_drained();
    tail = 0;
    while (tail < 300) begin
      @(negedge clk);
      tail++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/sha_pkg.sv
rtl/sha256_stream_hash.sv
dv/tb_sha256_stream_hash.sv
